### hdl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg: shared types and constants of the table line tokenizer
// Lexer modes, result kinds, error classes, character codes and the
// character class helpers used by the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlt_pkg;

  localparam int DEFAULT_MAX_DEPTH = 255;

  typedef enum logic [3:0] {
    M_START      = 4'd0,
    M_COMMENT    = 4'd1,
    M_DEPTH      = 4'd2,
    M_NAME_START = 4'd3,
    M_NAME       = 4'd4,
    M_POST_NAME  = 4'd5,
    M_VALUE      = 4'd6,
    M_POST_VALUE = 4'd7,
    M_HALT       = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    K_NONE      = 3'd0,
    K_NAME_CHAR = 3'd1,
    K_VAL_CHAR  = 3'd2,
    K_LINE_OP   = 3'd3,
    K_ERROR     = 3'd4
  } kind_t;

  localparam logic [2:0] E_BAD_LINE_START = 3'd0;
  localparam logic [2:0] E_EARLY_END      = 3'd1;
  localparam logic [2:0] E_AFTER_DEPTH    = 3'd2;
  localparam logic [2:0] E_IN_NAME        = 3'd3;
  localparam logic [2:0] E_AFTER_NAME     = 3'd4;
  localparam logic [2:0] E_NL_IN_QUOTES   = 3'd5;
  localparam logic [2:0] E_IN_VALUE       = 3'd6;
  localparam logic [2:0] E_AFTER_VALUE    = 3'd7;

  localparam logic [7:0] CH_NEWLINE    = 8'd10;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_QUOTE      = 8'd34;
  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_DOT        = 8'd46;
  localparam logic [7:0] CH_COLON      = 8'd58;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_TILDE      = 8'd126;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_char;
    logic [7:0] depth;
    logic       has_value;
    logic [2:0] error_code;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_letter(c) || is_digit(c);
  endfunction

endpackage

`default_nettype wire

### hdl/table_line_tokenizer.sv
// ----------------------------------------------------------------------------
// table_line_tokenizer: per-byte lexer for "colons name [value] [~comment]"
// Classifies each text byte and emits one token word per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: text_byte with in_valid / in_ready, one byte per word.
//   Output channel: kind, out_char, depth, has_value, error_code with
//   out_valid / out_ready, exactly one word per accepted byte, in order.
//   Each byte's mode transition is resolved in the cycle it is accepted and
//   its token word is written to the output register, or to the skid entry
//   if that is held; throughput is 1 byte per cycle while in_ready is high.
//   A two-entry output stage (register plus skid) keeps in_ready high while
//   a finished word waits; in_ready drops only when both entries are full,
//   i.e. in the cycle after the receiver stalls a full output register while
//   another byte is accepted.
//   After a syntax error the lexer halts and reports kind 0 for every byte
//   until reset. Synchronous reset (rst) returns the lexer to line start,
//   clears the colon count and flags, and empties the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module table_line_tokenizer
  import tlt_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] text_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      kind,
  output logic [7:0]      out_char,
  output logic [7:0]      depth,
  output logic            has_value,
  output logic [2:0]      error_code
);

  localparam logic [7:0] DepthLimit = 8'(MAX_DEPTH);

  mode_t      lex_mode, lex_mode_next;
  logic [7:0] colon_count, colon_count_next;
  logic       in_quotes, in_quotes_next;
  logic       name_seen, name_seen_next;

  result_t res;
  result_t out_reg, skid_reg;
  logic    out_full, skid_full;
  logic    accept, take;

  logic [7:0] c;
  logic       eol, line_end;

  assign c        = text_byte;
  assign eol      = (c == CH_NEWLINE);
  assign line_end = eol || (c == CH_TILDE);

  assign in_ready = !skid_full;
  assign accept   = in_valid && in_ready;
  assign take     = out_full && out_ready;

  // token word for the current byte
  always_comb begin
    res = '0;
    res.kind = K_NONE;
    case (lex_mode)
      M_START: begin
        if (!line_end && !is_blank(c) && c != CH_COLON) begin
          res.kind = K_ERROR;
          res.error_code = E_BAD_LINE_START;
        end
      end
      M_DEPTH: begin
        if (line_end) begin
          res.kind = K_ERROR;
          res.error_code = E_EARLY_END;
        end else if (is_blank(c) || c == CH_COLON) begin
          res.kind = K_NONE;
        end else if (is_letter(c) || c == CH_UNDERSCORE) begin
          res.kind = K_NAME_CHAR;
          res.out_char = c;
        end else begin
          res.kind = K_ERROR;
          res.error_code = E_AFTER_DEPTH;
        end
      end
      M_NAME_START, M_NAME: begin
        if (line_end) begin
          if (!name_seen) begin
            res.kind = K_ERROR;
            res.error_code = E_EARLY_END;
          end else begin
            res.kind = K_LINE_OP;
            res.depth = colon_count;
          end
        end else if (is_alnum(c) || (name_seen && c == CH_UNDERSCORE)) begin
          res.kind = K_NAME_CHAR;
          res.out_char = c;
        end else if (!is_blank(c)) begin
          res.kind = K_ERROR;
          res.error_code = E_IN_NAME;
        end
      end
      M_POST_NAME: begin
        if (line_end) begin
          res.kind = K_LINE_OP;
          res.depth = colon_count;
        end else if (is_blank(c)) begin
          res.kind = K_NONE;
        end else if (is_alnum(c) || c == CH_UNDERSCORE || c == CH_QUOTE || c == CH_MINUS) begin
          res.kind = K_VAL_CHAR;
          res.out_char = c;
        end else begin
          res.kind = K_ERROR;
          res.error_code = E_AFTER_NAME;
        end
      end
      M_VALUE: begin
        if (in_quotes) begin
          if (eol) begin
            res.kind = K_ERROR;
            res.error_code = E_NL_IN_QUOTES;
          end else begin
            res.kind = K_VAL_CHAR;
            res.out_char = c;
          end
        end else if (line_end) begin
          res.kind = K_LINE_OP;
          res.depth = colon_count;
          res.has_value = 1'b1;
        end else if (is_blank(c)) begin
          res.kind = K_NONE;
        end else if (is_alnum(c) || c == CH_UNDERSCORE || c == CH_DOT || c == CH_MINUS) begin
          res.kind = K_VAL_CHAR;
          res.out_char = c;
        end else begin
          res.kind = K_ERROR;
          res.error_code = E_IN_VALUE;
        end
      end
      M_POST_VALUE: begin
        if (line_end) begin
          res.kind = K_LINE_OP;
          res.depth = colon_count;
          res.has_value = 1'b1;
        end else if (!is_blank(c)) begin
          res.kind = K_ERROR;
          res.error_code = E_AFTER_VALUE;
        end
      end
      default: begin
        res.kind = K_NONE;
      end
    endcase
  end

  // lexer state update
  always_comb begin
    lex_mode_next    = lex_mode;
    colon_count_next = colon_count;
    in_quotes_next   = in_quotes;
    name_seen_next   = name_seen;
    case (lex_mode)
      M_START: begin
        if (line_end) begin
          lex_mode_next = M_COMMENT;
        end else if (c == CH_COLON) begin
          lex_mode_next    = M_DEPTH;
          colon_count_next = 8'd1;
        end
      end
      M_COMMENT: begin
        lex_mode_next = M_COMMENT;
      end
      M_DEPTH: begin
        if (line_end) begin
          lex_mode_next = M_DEPTH;
        end else if (is_blank(c)) begin
          lex_mode_next  = M_NAME_START;
          name_seen_next = 1'b0;
        end else if (is_letter(c) || c == CH_UNDERSCORE) begin
          lex_mode_next  = M_NAME;
          name_seen_next = 1'b1;
        end else if (c == CH_COLON) begin
          if (colon_count < DepthLimit) begin
            colon_count_next = colon_count + 8'd1;
          end
        end
      end
      M_NAME_START, M_NAME: begin
        if (line_end) begin
          if (name_seen) begin
            lex_mode_next = M_COMMENT;
          end
        end else if (is_alnum(c) || (name_seen && c == CH_UNDERSCORE)) begin
          name_seen_next = 1'b1;
          lex_mode_next  = M_NAME;
        end else if (is_blank(c) && lex_mode == M_NAME) begin
          lex_mode_next = M_POST_NAME;
        end
      end
      M_POST_NAME: begin
        if (line_end) begin
          lex_mode_next = M_COMMENT;
        end else if (is_alnum(c) || c == CH_UNDERSCORE || c == CH_QUOTE || c == CH_MINUS) begin
          in_quotes_next = (c == CH_QUOTE);
          lex_mode_next  = M_VALUE;
        end
      end
      M_VALUE: begin
        if (in_quotes) begin
          if (!eol && c == CH_QUOTE) begin
            in_quotes_next = 1'b0;
            lex_mode_next  = M_POST_VALUE;
          end
        end else if (line_end) begin
          lex_mode_next = M_COMMENT;
        end else if (is_blank(c)) begin
          lex_mode_next = M_POST_VALUE;
        end
      end
      M_POST_VALUE: begin
        if (line_end) begin
          lex_mode_next = M_COMMENT;
        end
      end
      default: begin
        lex_mode_next = M_HALT;
      end
    endcase

    // errors halt; outside the halt a newline returns to line start
    if (res.kind == K_ERROR) begin
      lex_mode_next = M_HALT;
    end else if (eol && lex_mode_next != M_HALT) begin
      lex_mode_next  = M_START;
      in_quotes_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode    <= M_START;
      colon_count <= '0;
      in_quotes   <= 1'b0;
      name_seen   <= 1'b0;
    end else if (accept) begin
      lex_mode    <= lex_mode_next;
      colon_count <= colon_count_next;
      in_quotes   <= in_quotes_next;
      name_seen   <= name_seen_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (!out_full || take) begin
        if (skid_full) begin
          out_full  <= 1'b1;
          skid_full <= accept;
        end else begin
          out_full <= accept;
        end
      end else if (accept) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || take) begin
      if (skid_full) begin
        out_reg <= skid_reg;
        if (accept) begin
          skid_reg <= res;
        end
      end else if (accept) begin
        out_reg <= res;
      end
    end else if (accept) begin
      skid_reg <= res;
    end
  end

  assign out_valid  = out_full;
  assign kind       = out_reg.kind;
  assign out_char   = out_reg.out_char;
  assign depth      = out_reg.depth;
  assign has_value  = out_reg.has_value;
  assign error_code = out_reg.error_code;

endmodule

`default_nettype wire

### tb/sv/table_line_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// table_line_tokenizer_checker: token word predictor and scoreboard
// Watches both channels of the tokenizer. Every accepted text byte runs
// through a local copy of the lexer and the token word it should produce is
// queued. Every accepted output word is compared field by field with the
// oldest queued word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_line_tokenizer_checker
  import tlt_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] kind,
  input  logic [7:0] out_char,
  input  logic [7:0] depth,
  input  logic       has_value,
  input  logic [2:0] error_code,
  output int         mismatches,
  output int         backlog,
  output int         line_ops,
  output int         char_words
);

  // local lexer state
  mode_t      lex_mode;
  logic [7:0] colons;
  logic       in_quote;
  logic       named;

  result_t expected_tokens[$];
  result_t want;
  result_t tok;

  function automatic logic space_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic alnum_char(input logic [7:0] c);
    return alpha_char(c) || (c >= 8'd48 && c <= 8'd57);
  endfunction

  function automatic result_t error_word(input logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = K_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic result_t char_word(input kind_t k, input logic [7:0] c);
    result_t r;
    r = '0;
    r.kind = k;
    r.out_char = c;
    return r;
  endfunction

  function automatic result_t line_word(input logic hv);
    result_t r;
    r = '0;
    r.kind = K_LINE_OP;
    r.depth = colons;
    r.has_value = hv;
    return r;
  endfunction

  // one lexer step: updates the local state and gives the token word
  task automatic lex_byte(input logic [7:0] c, output result_t res);
    logic eol;
    logic ends;
    eol = (c == CH_NEWLINE);
    ends = eol || (c == CH_TILDE);
    res = '0;
    case (lex_mode)
      M_START: begin
        if (ends) lex_mode = M_COMMENT;
        else if (c == CH_COLON) begin
          lex_mode = M_DEPTH;
          colons = 8'd1;
        end else if (!space_char(c)) res = error_word(E_BAD_LINE_START);
      end
      M_COMMENT: ;
      M_DEPTH: begin
        if (ends) res = error_word(E_EARLY_END);
        else if (space_char(c)) begin
          lex_mode = M_NAME_START;
          named = 1'b0;
        end else if (alpha_char(c) || c == CH_UNDERSCORE) begin
          lex_mode = M_NAME;
          named = 1'b1;
          res = char_word(K_NAME_CHAR, c);
        end else if (c == CH_COLON) begin
          if (colons < MAX_DEPTH) colons++;
        end else res = error_word(E_AFTER_DEPTH);
      end
      M_NAME_START, M_NAME: begin
        if (ends) begin
          if (!named) res = error_word(E_EARLY_END);
          else begin
            res = line_word(1'b0);
            lex_mode = M_COMMENT;
          end
        end else if (alnum_char(c) || (named && c == CH_UNDERSCORE)) begin
          named = 1'b1;
          lex_mode = M_NAME;
          res = char_word(K_NAME_CHAR, c);
        end else if (space_char(c)) begin
          if (lex_mode == M_NAME) lex_mode = M_POST_NAME;
        end else res = error_word(E_IN_NAME);
      end
      M_POST_NAME: begin
        if (ends) begin
          res = line_word(1'b0);
          lex_mode = M_COMMENT;
        end else if (space_char(c)) ;
        else if (alnum_char(c) || c == CH_UNDERSCORE || c == CH_QUOTE || c == CH_MINUS) begin
          in_quote = (c == CH_QUOTE);
          lex_mode = M_VALUE;
          res = char_word(K_VAL_CHAR, c);
        end else res = error_word(E_AFTER_NAME);
      end
      M_VALUE: begin
        if (in_quote) begin
          if (eol) res = error_word(E_NL_IN_QUOTES);
          else begin
            // closing quote is still part of the value
            if (c == CH_QUOTE) begin
              in_quote = 1'b0;
              lex_mode = M_POST_VALUE;
            end
            res = char_word(K_VAL_CHAR, c);
          end
        end else if (ends) begin
          res = line_word(1'b1);
          lex_mode = M_COMMENT;
        end else if (space_char(c)) lex_mode = M_POST_VALUE;
        else if (alnum_char(c) || c == CH_UNDERSCORE || c == CH_DOT || c == CH_MINUS)
          res = char_word(K_VAL_CHAR, c);
        else res = error_word(E_IN_VALUE);
      end
      M_POST_VALUE: begin
        if (ends) begin
          res = line_word(1'b1);
          lex_mode = M_COMMENT;
        end else if (!space_char(c)) res = error_word(E_AFTER_VALUE);
      end
      default: lex_mode = M_HALT;
    endcase
    if (res.kind == K_ERROR) lex_mode = M_HALT;
    else if (eol && lex_mode != M_HALT) begin
      lex_mode = M_START;
      in_quote = 1'b0;
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lex_mode = M_START;
      colons = '0;
      in_quote = 1'b0;
      named = 1'b0;
      expected_tokens.delete();
      backlog <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("kind: expected no word, got %0d", kind);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", 8'(want.kind), 8'(kind));
          check_field("out_char", want.out_char, out_char);
          check_field("depth", want.depth, depth);
          check_field("has_value", 8'(want.has_value), 8'(has_value));
          check_field("error_code", 8'(want.error_code), 8'(error_code));
        end
      end
      if (in_valid && in_ready) begin
        lex_byte(text_byte, tok);
        expected_tokens = {expected_tokens, tok};
        if (tok.kind == K_LINE_OP) line_ops++;
        else if (tok.kind == K_NAME_CHAR || tok.kind == K_VAL_CHAR) char_words++;
      end
      backlog <= expected_tokens.size();
    end
  end

endmodule

### tb/sv/table_line_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// table_line_tokenizer_tb: stimulus and verdict for the line tokenizer
// Sends a short hand-written set of lines, then random table lines (all
// well formed, with random names, values, quoted literals and comments),
// under three idle patterns, and ends with one broken line of a random error
// class followed by noise to exercise the halt. The checker does the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_line_tokenizer_tb;
  import tlt_pkg::*;

  localparam int PHASE_BYTES  = 380;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] out_char;
  logic [7:0] depth;
  logic       has_value;
  logic [2:0] error_code;

  int mismatches;
  int backlog;
  int line_ops;
  int char_words;

  int send_idle = 0;
  int recv_idle = 0;
  int bytes_sent = 0;
  int quiet = 0;
  logic [2:0] last_error;
  logic [7:0] line_bytes[$];

  always #10 clk = ~clk;

  table_line_tokenizer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_char  (out_char),
    .depth     (depth),
    .has_value (has_value),
    .error_code(error_code)
  );

  table_line_tokenizer_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_char  (out_char),
    .depth     (depth),
    .has_value (has_value),
    .error_code(error_code),
    .mismatches(mismatches),
    .backlog   (backlog),
    .line_ops  (line_ops),
    .char_words(char_words)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // ends the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? 8'(97 + r) : 8'(65 + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(48 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(9);
    if (r == 0) return CH_UNDERSCORE;
    else if (r < 3) return rand_digit();
    else return rand_letter();
  endfunction

  function automatic logic [7:0] rand_value_char();
    int r;
    r = $urandom_range(9);
    if (r == 0) return CH_DOT;
    else if (r == 1) return CH_MINUS;
    else return rand_word_char();
  endfunction

  // a byte that no line position outside quotes or comments accepts
  function automatic logic stray_byte(input logic [7:0] b);
    return !(b >= 8'd9 && b <= 8'd13) && b != CH_SPACE &&
           !(b >= 8'd48 && b <= 8'd57) && !(b >= 8'd65 && b <= 8'd90) &&
           !(b >= 8'd97 && b <= 8'd122) && b != CH_UNDERSCORE && b != CH_MINUS &&
           b != CH_DOT && b != CH_QUOTE && b != CH_COLON && b != CH_TILDE;
  endfunction

  function automatic logic [7:0] rand_stray();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (!stray_byte(b));
    return b;
  endfunction

  task automatic put(input logic [7:0] b);
    line_bytes = {line_bytes, b};
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_blanks(input int lo, input int hi);
    int n;
    int r;
    n = $urandom_range(hi, lo);
    repeat (n) begin
      r = $urandom_range(4);
      put(r == 4 ? CH_SPACE : (r == 0 ? 8'd9 : 8'(10 + r)));
    end
  endtask

  task automatic put_comment();
    logic [7:0] b;
    put(CH_TILDE);
    repeat ($urandom_range(8)) begin
      do b = 8'($urandom_range(255)); while (b == CH_NEWLINE);
      put(b);
    end
  endtask

  task automatic build_op_line(input int n_colons);
    logic [7:0] b;
    put_blanks(0, 2);
    repeat (n_colons) put(CH_COLON);
    if ($urandom_range(1)) put($urandom_range(3) == 0 ? CH_UNDERSCORE : rand_letter());
    else begin
      put_blanks(1, 2);
      put($urandom_range(1) ? rand_letter() : rand_digit());
    end
    repeat ($urandom_range(6)) put(rand_word_char());
    case ($urandom_range(2))
      1: begin
        put_blanks(1, 2);
        put($urandom_range(4) == 0 ? CH_MINUS : rand_word_char());
        repeat ($urandom_range(5)) put(rand_value_char());
      end
      2: begin
        put_blanks(1, 2);
        put(CH_QUOTE);
        repeat ($urandom_range(6)) begin
          do b = 8'($urandom_range(255)); while (b == CH_NEWLINE || b == CH_QUOTE);
          put(b);
        end
        put(CH_QUOTE);
      end
      default: ;
    endcase
    if ($urandom_range(1)) put_blanks(1, 2);
    if ($urandom_range(1)) put_comment();
    put(CH_NEWLINE);
  endtask

  task automatic build_random_line();
    int r;
    r = $urandom_range(99);
    if (r < 8) put_blanks(0, 3);
    else if (r < 16) begin
      put_blanks(0, 2);
      put_comment();
    end else begin
      build_op_line($urandom_range(99) < 4 ? $urandom_range(20, 5) : $urandom_range(3, 1));
      return;
    end
    put(CH_NEWLINE);
  endtask

  task automatic build_broken_line(input logic [2:0] cls);
    case (cls)
      E_BAD_LINE_START: begin
        put_blanks(0, 1);
        put($urandom_range(1) ? rand_stray() : rand_letter());
      end
      E_EARLY_END: begin
        put_text(":");
        if ($urandom_range(1)) put(CH_SPACE);
        put($urandom_range(1) ? CH_NEWLINE : CH_TILDE);
      end
      E_AFTER_DEPTH: begin
        put_text("::");
        put($urandom_range(1) ? rand_stray() : rand_digit());
      end
      E_IN_NAME: begin
        // a name may not start with an underscore after blanks
        if ($urandom_range(1)) put_text(": _");
        else begin
          put_text(":ab");
          put(rand_stray());
        end
      end
      E_AFTER_NAME: begin
        put_text(":ab ");
        put(rand_stray());
      end
      E_NL_IN_QUOTES: begin
        put_text(":ab \"x~");
        put(CH_NEWLINE);
      end
      E_IN_VALUE: begin
        put_text(":ab v1");
        put(rand_stray());
      end
      default: begin
        put_text(":ab v1 ");
        put($urandom_range(1) ? rand_stray() : rand_letter());
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    while (line_bytes.size() != 0) send_byte(line_bytes.pop_front());
  endtask

  task automatic send_random_until(input int target);
    while (bytes_sent < target) begin
      build_random_line();
      send_line();
    end
  endtask

  // hold the sender until the checker has nothing outstanding
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle = 20;
    recv_idle = 88;
    // hand-written lines: comment with a high byte, empty line, name only,
    // underscore name with a dotted value and comment, digit name with a
    // quoted value holding a tilde
    put_text("~");
    put(8'hff);
    put(CH_NEWLINE);
    put(CH_NEWLINE);
    put_text(" :a");
    put(CH_NEWLINE);
    put_text("::_b -1.x~");
    put(CH_NEWLINE);
    put(8'd9);
    put_text(": 9 \"~");
    put(8'h80);
    put_text("\" ");
    put(CH_NEWLINE);
    send_line();
    send_random_until(PHASE_BYTES / 2);
    wait_drained();
    send_random_until(PHASE_BYTES);

    send_idle = 88;
    recv_idle = 20;
    send_random_until(2 * PHASE_BYTES);

    send_idle = 0;
    recv_idle = 0;
    // colon run around the depth saturation point
    build_op_line($urandom_range(258, 254));
    send_line();
    send_random_until(3 * PHASE_BYTES);
    last_error = 3'($urandom_range(7));
    build_broken_line(last_error);
    send_line();
    repeat (20) send_byte(8'($urandom_range(255)));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d bytes: %0d line operations, %0d name/value chars",
             bytes_sent, line_ops, char_words);
    $display("closing line broke with error class %0d, then halted on noise", last_error);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
hdl/tlt_pkg.sv
hdl/table_line_tokenizer.sv
tb/sv/table_line_tokenizer_checker.sv
tb/sv/table_line_tokenizer_tb.sv
